[sv/ffa_pkg.sv]
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit free-list allocator: arena
// geometry, item structs, status and command codes and the controller states.
// ---------------------------------------------------------------------------
package ffa_pkg;

    // Arena geometry: unit 0 is the sentinel, units 1..ARENA_UNITS the arena
    localparam int ARENA_UNITS = 4095;
    localparam int UNIT_BYTES  = 16;
    localparam int STORE_DEPTH = ARENA_UNITS + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int STEP_LIMIT  = ARENA_UNITS + 2;
    localparam int STEP_W      = $clog2(STEP_LIMIT + 1);
    localparam int BYTES_W     = 16;
    localparam int MIN_RELEASE = 2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_SIZE = 2'd1,
        STAT_NO_SPACE = 2'd2,
        STAT_IGNORED  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic [BYTES_W-1:0] request_bytes;
        t_idx               block_address;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_idx    payload_address;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ALLOC_LINK,
        ST_ALLOC_EVAL,
        ST_ALLOC_SPLIT,
        ST_REL_WALK,
        ST_REL_BLK,
        ST_REL_NXT,
        ST_REL_CUR,
        ST_RESULT
    } t_state;

endpackage

[sv/ffa_ram.sv]
// ---------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/first_fit_free_list_allocator.sv]
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over a fixed arena with an address-ordered circular
// free list, a roving search start and merge on release.
// ---------------------------------------------------------------------------
// After reset the block sweeps all 4096 entries of its link and size memories,
// one entry a cycle, before it takes the first command. It then takes one
// command at a time, and reads each list entry it visits through the
// registered read port of the link/size memories. An allocate runs START,
// ALLOC_LINK, ALLOC_EVAL once per free-list entry examined, ALLOC_SPLIT when
// the block is split, and RESULT. A release runs START, REL_WALK once per entry
// examined, REL_BLK, REL_NXT, REL_CUR and RESULT, but ends after REL_BLK when
// the header holds size zero; a rejected size or address goes from START to
// RESULT. The block is ready again as the result enters the output register.
// A finished result waits there as the next command is taken; if that register
// is still full when the next result is done, the block holds until it drains.
module first_fit_free_list_allocator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ffa_pkg::t_in_item  i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ffa_pkg::t_out_item o_out_item
);

    import ffa_pkg::*;

    // Registers and their next values
    t_state    r_state, n_state;
    t_in_item  r_in, n_in;
    t_idx      r_need, n_need;
    t_idx      r_prev, n_prev;
    t_idx      r_cur, n_cur;
    t_idx      r_nxt, n_nxt;
    t_idx      r_hdr, n_hdr;
    t_idx      r_size_cur, n_size_cur;
    t_idx      r_size_blk, n_size_blk;
    t_step     r_steps, n_steps;
    t_idx      r_rover, n_rover;
    t_idx      r_clr, n_clr;
    t_out_item r_res, n_res;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Memory ports
    t_idx mem_raddr;
    t_idx mem_waddr;
    logic link_we, size_we;
    t_idx link_wdata, size_wdata;
    t_idx link_rd, size_rd;

    // Derived values
    logic [BYTES_W:0] bytes_sum;
    logic [BYTES_W:0] need_full;
    logic             alloc_bad;
    logic             rel_bad;
    t_idx             blk;
    logic             alloc_limit, alloc_fit, alloc_exact, alloc_lap;
    t_idx             size_left;
    logic [IDX_W:0]   hdr_sum;
    t_idx             hdr;
    logic             rel_limit, rel_found;
    logic             upper_merge, lower_merge;
    logic             out_free;

    ffa_ram #(.WIDTH(IDX_W), .DEPTH(STORE_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (mem_waddr),
        .i_wdata (link_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (link_rd)
    );

    ffa_ram #(.WIDTH(IDX_W), .DEPTH(STORE_DEPTH)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (mem_waddr),
        .i_wdata (size_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (size_rd)
    );

    // Request size in units plus one header unit
    assign bytes_sum = {1'b0, r_in.request_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1);
    assign need_full = (bytes_sum / (BYTES_W+1)'(UNIT_BYTES)) + (BYTES_W+1)'(1);
    assign alloc_bad = (r_in.request_bytes == '0)
                    || (need_full > (BYTES_W+1)'(ARENA_UNITS));
    assign rel_bad   = (r_in.block_address < IDX_W'(MIN_RELEASE))
                    || ({1'b0, r_in.block_address} > (IDX_W+1)'(ARENA_UNITS));
    assign blk       = r_in.block_address - IDX_W'(1);

    // Allocate walk decisions on the entry just read
    assign alloc_limit = (r_steps == STEP_W'(STEP_LIMIT));
    assign alloc_fit   = (size_rd >= r_need);
    assign alloc_exact = (size_rd == r_need);
    assign alloc_lap   = (r_cur == r_rover);
    assign size_left   = size_rd - r_need;
    assign hdr_sum     = {1'b0, r_cur} + {1'b0, size_left};
    assign hdr         = (hdr_sum < (IDX_W+1)'(STORE_DEPTH)) ? hdr_sum[IDX_W-1:0] : '0;

    // Release walk: is the block's place between cur and the entry just read
    assign rel_limit = (r_steps == STEP_W'(STEP_LIMIT));
    assign rel_found = ((blk > r_cur) && (blk < link_rd))
                    || ((r_cur >= link_rd) && ((blk > r_cur) || (blk < link_rd)));

    // Merge tests
    assign upper_merge = (({1'b0, blk} + {1'b0, r_size_blk}) == {1'b0, r_nxt});
    assign lower_merge = (({1'b0, r_cur} + {1'b0, r_size_cur}) == {1'b0, blk});

    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == IDX_W'(STORE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_START;
            end
            ST_START: begin
                if (r_in.command == CMD_ALLOC) begin
                    n_state = alloc_bad ? ST_RESULT : ST_ALLOC_LINK;
                end else begin
                    n_state = rel_bad ? ST_RESULT : ST_REL_WALK;
                end
            end
            ST_ALLOC_LINK: n_state = ST_ALLOC_EVAL;
            ST_ALLOC_EVAL: begin
                if (alloc_limit) begin
                    n_state = ST_RESULT;
                end else if (alloc_fit) begin
                    n_state = alloc_exact ? ST_RESULT : ST_ALLOC_SPLIT;
                end else if (alloc_lap) begin
                    n_state = ST_RESULT;
                end
            end
            ST_ALLOC_SPLIT: n_state = ST_RESULT;
            ST_REL_WALK: begin
                if (rel_limit) n_state = ST_RESULT;
                else if (rel_found) n_state = ST_REL_BLK;
            end
            ST_REL_BLK: begin
                n_state = (size_rd == '0) ? ST_RESULT : ST_REL_NXT;
            end
            ST_REL_NXT: n_state = ST_REL_CUR;
            ST_REL_CUR: n_state = ST_RESULT;
            ST_RESULT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake and memory controls
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        mem_raddr  = r_rover;
        mem_waddr  = r_cur;
        link_we    = 1'b0;
        size_we    = 1'b0;
        link_wdata = r_nxt;
        size_wdata = r_size_cur;
        unique case (r_state)
            ST_CLEAR: begin
                mem_waddr  = r_clr;
                link_we    = 1'b1;
                size_we    = 1'b1;
                link_wdata = (r_clr == IDX_W'(0)) ? IDX_W'(1) : '0;
                size_wdata = (r_clr == IDX_W'(1)) ? IDX_W'(ARENA_UNITS) : '0;
            end
            ST_START: mem_raddr = r_rover;
            ST_ALLOC_LINK: mem_raddr = link_rd;
            ST_ALLOC_EVAL: begin
                mem_raddr = link_rd;
                if (!alloc_limit && alloc_fit) begin
                    if (alloc_exact) begin
                        // Unlink the whole block
                        mem_waddr  = r_prev;
                        link_we    = 1'b1;
                        link_wdata = link_rd;
                    end else begin
                        // Shrink the block, its tail is handed out
                        mem_waddr  = r_cur;
                        size_we    = 1'b1;
                        size_wdata = size_left;
                    end
                end
            end
            ST_ALLOC_SPLIT: begin
                mem_waddr  = r_hdr;
                size_we    = 1'b1;
                size_wdata = r_need;
            end
            ST_REL_WALK: mem_raddr = rel_found ? blk : link_rd;
            ST_REL_BLK: mem_raddr = r_nxt;
            ST_REL_NXT: begin
                // Write the released block, merged with its upper neighbour
                mem_waddr  = blk;
                link_we    = 1'b1;
                size_we    = 1'b1;
                link_wdata = upper_merge ? link_rd : r_nxt;
                size_wdata = upper_merge ? (r_size_blk + size_rd) : r_size_blk;
            end
            ST_REL_CUR: begin
                // Point the lower neighbour at it, or absorb it
                mem_waddr  = r_cur;
                link_we    = 1'b1;
                size_we    = 1'b1;
                link_wdata = lower_merge ? r_nxt : blk;
                size_wdata = lower_merge ? (r_size_cur + r_size_blk) : r_size_cur;
            end
            ST_IDLE, ST_RESULT: ;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_in        = r_in;
        n_need      = r_need;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_hdr       = r_hdr;
        n_size_cur  = r_size_cur;
        n_size_blk  = r_size_blk;
        n_steps     = r_steps;
        n_rover     = r_rover;
        n_clr       = r_clr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_CLEAR: n_clr = r_clr + IDX_W'(1);
            ST_IDLE: begin
                if (i_in_valid) n_in = i_in_item;
            end
            ST_START: begin
                n_steps = '0;
                if (r_in.command == CMD_ALLOC) begin
                    n_need = need_full[IDX_W-1:0];
                    n_prev = r_rover;
                    n_res  = '{status: STAT_BAD_SIZE, payload_address: '0};
                end else begin
                    n_cur = r_rover;
                    n_res = '{status: STAT_IGNORED, payload_address: '0};
                end
            end
            ST_ALLOC_LINK: begin
                n_cur = link_rd;
                n_res = '{status: STAT_NO_SPACE, payload_address: '0};
            end
            ST_ALLOC_EVAL: begin
                if (!alloc_limit) begin
                    if (alloc_fit) begin
                        n_rover = r_prev;
                        n_hdr   = hdr;
                        n_res   = '{status: STAT_OK,
                                    payload_address: (alloc_exact ? r_cur : hdr) + IDX_W'(1)};
                    end else if (!alloc_lap) begin
                        // Advance to the next free block
                        n_prev  = r_cur;
                        n_cur   = link_rd;
                        n_steps = r_steps + STEP_W'(1);
                    end
                end
            end
            ST_REL_WALK: begin
                if (!rel_limit) begin
                    if (rel_found) begin
                        n_nxt      = link_rd;
                        n_size_cur = size_rd;
                    end else begin
                        n_cur   = link_rd;
                        n_steps = r_steps + STEP_W'(1);
                    end
                end
            end
            ST_REL_BLK: n_size_blk = size_rd;
            ST_REL_NXT: begin
                // Keep the merged block's link and size for the lower merge
                n_nxt      = upper_merge ? link_rd : r_nxt;
                n_size_blk = upper_merge ? (r_size_blk + size_rd) : r_size_blk;
            end
            ST_REL_CUR: begin
                n_rover = r_cur;
                n_res   = '{status: STAT_OK, payload_address: '0};
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rover     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rover     <= n_rover;
            r_out_valid <= n_out_valid;
        end
        r_in       <= n_in;
        r_need     <= n_need;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_hdr      <= n_hdr;
        r_size_cur <= n_size_cur;
        r_size_blk <= n_size_blk;
        r_steps    <= n_steps;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[sv/ffa_checker.sv]
// ---------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator: beat accounting, failed results and
// the post-reset clearing sweep and the hold of a stalled result beat.
// ---------------------------------------------------------------------------
module ffa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ffa_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ffa_pkg::t_out_item i_out_item
);

    import ffa_pkg::*;

    logic [1:0] r_pending, n_pending;
    logic       in_beat, out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Count commands whose result beat is still owed
    always_comb begin
        n_pending = r_pending + {1'b0, in_beat} - {1'b0, out_beat};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // A result beat always answers an accepted command
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 2'd0))
        else $error("result shown with no command outstanding");

    // At most one command waits behind the output register
    a_one_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |-> (r_pending <= 2'd1))
        else $error("command accepted with two results owed");

    // A failed command hands out no address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_item.status != STAT_OK))
            |-> (i_out_item.payload_address == '0))
        else $error("failed command carries an address");

    // Clearing sweep holds off commands right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("command taken before the clearing sweep");

    // A waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)))
        else $error("result beat dropped or changed while stalled");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);
